### rtl/core/lcs_pkg.sv
// Shared constants, codes and types for the cell stencil stream.
package lcs_pkg;

   // Largest frame the line stores are sized for.
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_ROWS    = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH + 2;

   // Register field widths are fixed by the register map.
   localparam int CFG_WIDTH_W = 11;
   localparam int CFG_ROWS_W  = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   // Padded position counters; a column position also addresses the line stores.
   localparam int COL_W = $clog2(STORE_DEPTH);
   localparam int ROW_W = $clog2(MAX_ROWS + 2);

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 2);

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 1'b1;

   // Register reset values.
   localparam logic [CFG_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd64;
   localparam logic [CFG_ROWS_W-1:0]  ROW_COUNT_RESET = 13'd64;

   // One classified cell handed from front to back.
   typedef struct packed {
      logic [2:0] column;    // bit 0 top, bit 1 middle, bit 2 newest row
      logic       produce;   // window is centered on an interior cell
      logic       row_end;
      logic       frame_end;
   } lcs_work_type;

endpackage

### rtl/core/lcs_if.sv
// Channel interfaces for cell input and result output.
interface lcs_req_if;
   logic valid;
   logic ready;
   logic cell_in;

   modport source (output valid, output cell_in, input ready);
   modport sink (input valid, input cell_in, output ready);
endinterface

interface lcs_rsp_if;
   logic valid;
   logic ready;
   logic next_cell;
   logic row_end;
   logic frame_end;

   modport source (output valid, output next_cell, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input next_cell, input row_end, input frame_end,
                 output ready);
endinterface

### rtl/core/lcs_front.sv
// Front part: registers, position counters, line store and cell classification.
module lcs_front
   import lcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lcs_req_if.sink                req_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [QCNT_W-1:0]      q_count,
   output logic                   push_valid,
   output lcs_work_type           push_item
);

   logic [CFG_WIDTH_W-1:0] width_ff, width_in;
   logic [CFG_ROWS_W-1:0]  rows_ff, rows_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [31:0]            width_wide, rows_wide;
   logic [COL_W-1:0]       last_col;
   logic [ROW_W-1:0]       last_row;
   logic                   accept;
   logic                   addr_ok;
   logic                   produce;
   logic                   rend;

   // Stage after the line store read.
   logic                   s1_valid_ff;
   logic                   s1_cell_ff;
   logic                   s1_produce_ff;
   logic                   s1_rend_ff;
   logic                   s1_fend_ff;
   logic                   s1_wr_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   logic [1:0]             rd_ff;

   // Both line stores in one memory: bit 0 upper row, bit 1 middle row.
   logic [1:0]             store_mem [STORE_DEPTH];

   // Register writes.
   always_comb begin
      width_in = width_ff;
      rows_in  = rows_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_WIDTH: width_in = csr_wdata[CFG_WIDTH_W-1:0];
            CSR_ROW_COUNT: rows_in  = csr_wdata[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero counts as one; an oversized value saturates.
   always_comb begin
      if (width_ff == '0) begin
         width_wide = 32'd1;
      end else if ({{(32-CFG_WIDTH_W){1'b0}}, width_ff} > 32'(MAX_WIDTH)) begin
         width_wide = 32'(MAX_WIDTH);
      end else begin
         width_wide = {{(32-CFG_WIDTH_W){1'b0}}, width_ff};
      end
      if (rows_ff == '0) begin
         rows_wide = 32'd1;
      end else if ({{(32-CFG_ROWS_W){1'b0}}, rows_ff} > 32'(MAX_ROWS)) begin
         rows_wide = 32'(MAX_ROWS);
      end else begin
         rows_wide = {{(32-CFG_ROWS_W){1'b0}}, rows_ff};
      end
   end

   assign last_col = COL_W'(width_wide + 32'd1);
   assign last_row = ROW_W'(rows_wide + 32'd1);

   // Take a cell only when the queue has room for it and the one in flight.
   assign req_chan.ready = (q_count + {{(QCNT_W-1){1'b0}}, s1_valid_ff})
                           < QCNT_W'(QUEUE_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   // Classify the incoming cell by its padded position.
   assign produce = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2))
                    && (row_ff <= last_row) && (col_ff <= last_col);
   assign rend    = (col_ff == last_col);
   assign addr_ok = (col_ff < COL_W'(STORE_DEPTH));

   // Step the position, wrapping at the end of a row and of the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= last_col) begin
            col_in = '0;
            if (row_ff >= last_row) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ROW_WIDTH_RESET;
         rows_ff     <= ROW_COUNT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         rows_ff     <= rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff    <= req_chan.cell_in;
         s1_produce_ff <= produce;
         s1_rend_ff    <= rend;
         s1_fend_ff    <= rend && (row_ff == last_row);
         s1_wr_ff      <= addr_ok;
         s1_addr_ff    <= col_ff;
      end
   end

   // Line store: read on transfer, written back in the following cycle. The same
   // column comes round again at least three cells later, so the two never meet.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= store_mem[col_ff];
      end
      if (s1_valid_ff && s1_wr_ff) begin
         store_mem[s1_addr_ff] <= {s1_cell_ff, rd_ff[1]};
      end
   end

   // Column of the window for this cell; an address past the store reads as dead.
   assign push_valid          = s1_valid_ff;
   assign push_item.column    = s1_wr_ff ? {s1_cell_ff, rd_ff} : {s1_cell_ff, 2'b00};
   assign push_item.produce   = s1_produce_ff;
   assign push_item.row_end   = s1_rend_ff;
   assign push_item.frame_end = s1_fend_ff;

endmodule

### rtl/core/lcs_queue.sv
// Short queue of classified cells between front and back.
module lcs_queue
   import lcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lcs_work_type      push_item,
   input  logic              pop,
   output logic              pop_valid,
   output lcs_work_type      pop_item,
   output logic [QCNT_W-1:0] count
);

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;
   lcs_work_type      slot_ff [QUEUE_DEPTH];

   assign do_pop    = pop && (count_ff != '0);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + {{(QCNT_W-1){1'b0}}, push_valid}
                  - {{(QCNT_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/lcs_back.sv
// Back part: 3x3 window, B3/S23 rule and the result register.
module lcs_back
   import lcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   input  lcs_work_type pop_item,
   output logic         pop,
   lcs_rsp_if.source    rsp_chan
);

   logic [8:0] window_ff, window_in;
   logic       out_valid_ff, out_valid_in;
   logic       next_cell_ff;
   logic       row_end_ff;
   logic       frame_end_ff;
   logic [3:0] alive;
   logic       next_state;

   // Move on whenever the result register is free or being emptied.
   assign pop = pop_valid && (!out_valid_ff || rsp_chan.ready);

   // Oldest column leaves at the bottom, the new one enters at the top.
   assign window_in = {pop_item.column, window_ff[8:3]};

   // Count the eight neighbors around the center bit.
   always_comb begin
      alive = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            alive = alive + {3'b000, window_in[i]};
         end
      end
      next_state = (alive == 4'd3) || (window_in[4] && (alive == 4'd2));
   end

   // Result register occupancy.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (pop && pop_item.produce) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            window_ff <= window_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop && pop_item.produce) begin
         next_cell_ff <= next_state;
         row_end_ff   <= pop_item.row_end;
         frame_end_ff <= pop_item.frame_end;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.next_cell = next_cell_ff;
   assign rsp_chan.row_end   = row_end_ff;
   assign rsp_chan.frame_end = frame_end_ff;

endmodule

### rtl/core/life_cell_stencil_stream.sv
// Top level of the streaming B3/S23 cell stencil.
//
//   channel    direction  carries                          transfer when
//   req_chan   in         cell_in                          valid && ready
//   rsp_chan   out        next_cell, row_end, frame_end    valid && ready
//   csr_*      in         row_width (0), row_count (1)     csr_wr_en
//
// One cell is taken per cycle while the queue has room; the line store is read
// on transfer and written back the cycle after. A result goes through the stage
// register, queue and result register. Reset is synchronous and clears counters,
// queue and window; the line store is not cleared. A stalled output fills the
// result register and then the four-entry queue before the input is held off.
module life_cell_stencil_stream
   import lcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lcs_req_if.sink                req_chan,
   lcs_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic              push_valid;
   lcs_work_type      push_item;
   logic              pop;
   logic              pop_valid;
   lcs_work_type      pop_item;
   logic [QCNT_W-1:0] q_count;

   lcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   lcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .count      (q_count)
   );

   lcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
